/* hdl/dtpg_pkg.sv */
package dtpg_pkg;

    // Fixed widths of the voltage and tick fields
    localparam int VOLT_W         = 15;
    localparam int TICK_BITS      = 24;
    localparam int VOLT_FRAC_BITS = 10;
    localparam int EXP_TABLE_SIZE = 64;
    localparam int IDX_BITS       = $clog2(EXP_TABLE_SIZE);
    localparam int IP_BITS        = VOLT_W - VOLT_FRAC_BITS;

    // Q16 mantissa of 2^frac, one more bit for the integer part
    localparam int MANT_FRAC = 16;
    localparam int MANT_W    = MANT_FRAC + 1;
    localparam int PROD_W    = TICK_BITS + MANT_W;
    localparam int SHIFT_W   = 6;

    // Configuration register indexes
    localparam logic [2:0] REG_DELAY_BASE = 3'd0;
    localparam logic [2:0] REG_GATE_BASE  = 3'd1;
    localparam logic [2:0] REG_MAX_TICKS  = 3'd2;
    localparam logic [2:0] REG_MIN_GATE   = 3'd3;
    localparam logic [2:0] REG_EDGE_LOW   = 3'd4;
    localparam logic [2:0] REG_EDGE_HIGH  = 3'd5;

    // Schmitt comparisons and jack state, carried along the pipeline
    typedef struct packed {
        logic le_low;
        logic ge_high;
        logic trig_conn;
    } trig_flags_t;

    typedef logic [MANT_W-1:0] mant_tab_t [EXP_TABLE_SIZE];

    // round(2^(2^-(b+1)) * 2^16) for b = 0..15
    localparam logic [MANT_W-1:0] ROOT_Q16 [16] = '{
        17'd92682, 17'd77935, 17'd71468, 17'd68438, 17'd66971, 17'd66250,
        17'd65892, 17'd65714, 17'd65625, 17'd65580, 17'd65558, 17'd65547,
        17'd65542, 17'd65539, 17'd65537, 17'd65537
    };

    // Mantissa table, built at elaboration: product over the set bits of x
    function automatic mant_tab_t build_mant_tab();
        mant_tab_t   tab;
        logic [63:0] m;
        logic [15:0] x;
        for (int i = 0; i < EXP_TABLE_SIZE; i++)
        begin
            x = 16'((i * 65536) / EXP_TABLE_SIZE);
            m = 64'd65536;
            for (int b = 0; b < 16; b++)
            begin
                if (x[15-b])
                begin
                    m = (m * 64'(ROOT_Q16[b]) + 64'd32768) >> 16;
                end
            end
            tab[i] = MANT_W'(m);
        end
        return tab;
    endfunction

    localparam mant_tab_t MANT_TAB = build_mant_tab();

endpackage

/* hdl/dtpg_scale.sv */
// base * 2^cv clamped to [min_ticks, max_ticks]; base capped if !conn.
// Three stages: table lookup, multiply, shift and saturate.
module dtpg_scale
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [dtpg_pkg::VOLT_W-1:0]   cv,
    input  logic                                 conn,
    input  logic [dtpg_pkg::TICK_BITS-1:0]       base,
    input  logic [dtpg_pkg::TICK_BITS-1:0]       max_ticks,
    input  logic [dtpg_pkg::TICK_BITS-1:0]       min_ticks,
    output logic [dtpg_pkg::TICK_BITS-1:0]       result
);

    logic [dtpg_pkg::MANT_W-1:0]  mant_reg;
    logic [dtpg_pkg::SHIFT_W-1:0] sh1_reg, sh2_reg;
    logic                         conn1_reg, conn2_reg;
    logic [dtpg_pkg::PROD_W-1:0]  prod_reg;
    logic [dtpg_pkg::TICK_BITS-1:0] result_reg, result_next;

    logic [dtpg_pkg::IDX_BITS-1:0]     idx;
    logic signed [dtpg_pkg::IP_BITS-1:0] ip;
    logic [dtpg_pkg::SHIFT_W-1:0]      sh;
    logic [dtpg_pkg::PROD_W-1:0]       shifted;
    logic [dtpg_pkg::TICK_BITS-1:0]    sat, lo;

    // Split cv into integer octave and table index
    assign idx = cv[dtpg_pkg::VOLT_FRAC_BITS-1 -: dtpg_pkg::IDX_BITS];
    assign ip  = cv[dtpg_pkg::VOLT_W-1:dtpg_pkg::VOLT_FRAC_BITS];
    assign sh  = dtpg_pkg::SHIFT_W'(dtpg_pkg::MANT_FRAC - int'(ip));

    // Shift down, saturate, clamp
    always_comb
    begin
        shifted = prod_reg >> sh2_reg;
        sat     = (shifted > dtpg_pkg::PROD_W'(max_ticks)) ? max_ticks
                                                           : shifted[dtpg_pkg::TICK_BITS-1:0];
        lo      = (sat < min_ticks) ? min_ticks : sat;
        if (conn2_reg)
        begin
            result_next = (lo > max_ticks) ? max_ticks : lo;
        end
        else
        begin
            result_next = (base > max_ticks) ? max_ticks : base;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mant_reg   <= dtpg_pkg::MANT_TAB[idx];
            sh1_reg    <= sh;
            conn1_reg  <= conn;
            prod_reg   <= dtpg_pkg::PROD_W'(base) * dtpg_pkg::PROD_W'(mant_reg);
            sh2_reg    <= sh1_reg;
            conn2_reg  <= conn1_reg;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

/* hdl/dtpg_core.sv */
// Per-tick state update: Schmitt detector, delay countdown, pulse length.
// Drives the output register of the result channel.
module dtpg_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               step_valid,
    input  dtpg_pkg::trig_flags_t              flags,
    input  logic [dtpg_pkg::TICK_BITS-1:0]     delay_ticks,
    input  logic [dtpg_pkg::TICK_BITS-1:0]     gate_ticks,
    output logic                               out_valid,
    output logic                               pulse_out,
    output logic                               delay_busy
);

    logic                            armed_reg, armed_next;
    logic                            running_reg, running_next;
    logic [dtpg_pkg::TICK_BITS-1:0]  delay_left_reg, delay_left_next;
    logic [dtpg_pkg::TICK_BITS-1:0]  pulse_left_reg, pulse_left_next;
    logic                            valid_reg, pulse_reg, busy_reg, level;
    logic                            step, edge_det, fire;
    logic [dtpg_pkg::TICK_BITS-1:0]  dl, pl;
    logic                            run;

    assign step = en && step_valid;

    // Next state for one tick
    always_comb
    begin
        armed_next = armed_reg;
        edge_det   = 1'b0;
        if (armed_reg)
        begin
            if (flags.le_low)
            begin
                armed_next = 1'b0;
            end
        end
        else if (flags.ge_high)
        begin
            armed_next = 1'b1;
            edge_det   = 1'b1;
        end

        dl = delay_left_reg;
        run = running_reg;
        if (edge_det || (!running_reg && !flags.trig_conn))
        begin
            dl  = delay_ticks;
            run = 1'b1;
        end

        fire = 1'b0;
        delay_left_next = dl;
        running_next    = run;
        if (run)
        begin
            if (dl <= dtpg_pkg::TICK_BITS'(1))
            begin
                delay_left_next = '0;
                running_next    = 1'b0;
                fire            = 1'b1;
            end
            else
            begin
                delay_left_next = dl - dtpg_pkg::TICK_BITS'(1);
            end
        end

        pl = pulse_left_reg;
        if (fire && (gate_ticks > pl))
        begin
            pl = gate_ticks;
        end
        level           = (pl != '0);
        pulse_left_next = level ? (pl - dtpg_pkg::TICK_BITS'(1)) : pl;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= 1'b1;
            running_reg    <= 1'b0;
            delay_left_reg <= '0;
            pulse_left_reg <= '0;
            valid_reg      <= 1'b0;
            pulse_reg      <= 1'b0;
            busy_reg       <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                valid_reg <= step_valid;
            end
            if (step)
            begin
                armed_reg      <= armed_next;
                running_reg    <= running_next;
                delay_left_reg <= delay_left_next;
                pulse_left_reg <= pulse_left_next;
                pulse_reg      <= level;
                busy_reg       <= running_next;
            end
        end
    end

    assign out_valid  = valid_reg;
    assign pulse_out  = pulse_reg;
    assign delay_busy = busy_reg;

    // A running countdown always has ticks left; an idle one holds zero
    a_running_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (delay_left_reg != '0))
        else $error("delay running with zero ticks left");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !running_reg |-> (delay_left_reg == '0))
        else $error("idle delay counter not zero");

    // Pulse length only grows when the delay fires
    a_pulse_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        !(step && fire) |=> (pulse_left_reg <= $past(pulse_left_reg)))
        else $error("pulse length grew without a fire");

    // Busy flag of the last beat matches the countdown state
    a_busy_match: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (busy_reg == running_reg))
        else $error("delay_busy out of step with countdown");

endmodule

/* hdl/delayed_trigger_pulse_generator.sv */
// Delayed trigger pulse generator.
// One input beat on s_* is one sample tick; each produces exactly one
// result beat on m_*. A Schmitt detector finds rising trigger edges, which
// (or an idle timer with the trigger jack unplugged) reload a delay of
// delay_base_ticks * 2^delay_cv. When it expires a pulse of
// gate_base_ticks * 2^gate_cv ticks starts, unless a running pulse is longer.
// Throughput: one beat per clock while m_tready does not stall the pipe.
// The result passes the five-stage pipe (input register, table lookup,
// multiply, shift/saturate, state update with output register).
// Registers are written through cfg_wr_en/cfg_addr/cfg_wdata; the user must
// write them only while the block is idle (the block does not enforce it).
// Reset (rst_n low, asynchronous) loads the register defaults, arms the
// Schmitt detector high, and clears the delay and pulse counters.
// When a result beat is waiting and m_tready is low, the whole pipe holds
// and s_tready drops; no beat is lost and the timers advance only on
// accepted ticks.
module delayed_trigger_pulse_generator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [23:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [14:0] trig_level, [15] trig_connected, [30:16] delay_cv,
    // [31] delay_cv_connected, [46:32] gate_cv, [47] gate_cv_connected
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] pulse_out, [1] delay_busy, [7:2] zero
    output logic [7:0]  m_tdata
);

    logic [dtpg_pkg::TICK_BITS-1:0] delay_base_reg, gate_base_reg;
    logic [dtpg_pkg::TICK_BITS-1:0] max_ticks_reg, min_gate_reg;
    logic signed [dtpg_pkg::VOLT_W-1:0] edge_low_reg, edge_high_reg;

    logic                               en;
    logic [3:0]                         valid_reg;
    logic signed [dtpg_pkg::VOLT_W-1:0] trig_reg, dcv_reg, gcv_reg;
    logic                               tconn_reg, dconn_reg, gconn_reg;
    dtpg_pkg::trig_flags_t              flags1_reg, flags2_reg, flags3_reg, flags_next;
    logic [dtpg_pkg::TICK_BITS-1:0]     delay_ticks, gate_ticks;
    logic                               pulse_out, delay_busy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_base_reg <= 24'd7200;
            gate_base_reg  <= 24'd48;
            max_ticks_reg  <= 24'd240000;
            min_gate_reg   <= 24'd48;
            edge_low_reg   <= 15'sd102;
            edge_high_reg  <= 15'sd2048;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                dtpg_pkg::REG_DELAY_BASE: delay_base_reg <= cfg_wdata;
                dtpg_pkg::REG_GATE_BASE:  gate_base_reg  <= cfg_wdata;
                dtpg_pkg::REG_MAX_TICKS:  max_ticks_reg  <= cfg_wdata;
                dtpg_pkg::REG_MIN_GATE:   min_gate_reg   <= cfg_wdata;
                dtpg_pkg::REG_EDGE_LOW:   edge_low_reg   <= cfg_wdata[14:0];
                dtpg_pkg::REG_EDGE_HIGH:  edge_high_reg  <= cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    // Whole pipe advances unless a result beat is stalled
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], s_tvalid};
        end
    end

    // Input register and Schmitt comparisons
    always_comb
    begin
        flags_next.le_low    = (trig_reg <= edge_low_reg);
        flags_next.ge_high   = (trig_reg >= edge_high_reg);
        flags_next.trig_conn = tconn_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig_reg   <= s_tdata[14:0];
            tconn_reg  <= s_tdata[15];
            dcv_reg    <= s_tdata[30:16];
            dconn_reg  <= s_tdata[31];
            gcv_reg    <= s_tdata[46:32];
            gconn_reg  <= s_tdata[47];
            flags1_reg <= flags_next;
            flags2_reg <= flags1_reg;
            flags3_reg <= flags2_reg;
        end
    end

    // Delay path has no lower clamp
    dtpg_scale u_delay_scale
    (
        .clk       (clk),
        .en        (en),
        .cv        (dcv_reg),
        .conn      (dconn_reg),
        .base      (delay_base_reg),
        .max_ticks (max_ticks_reg),
        .min_ticks ('0),
        .result    (delay_ticks)
    );

    dtpg_scale u_gate_scale
    (
        .clk       (clk),
        .en        (en),
        .cv        (gcv_reg),
        .conn      (gconn_reg),
        .base      (gate_base_reg),
        .max_ticks (max_ticks_reg),
        .min_ticks (min_gate_reg),
        .result    (gate_ticks)
    );

    dtpg_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .step_valid  (valid_reg[3]),
        .flags       (flags3_reg),
        .delay_ticks (delay_ticks),
        .gate_ticks  (gate_ticks),
        .out_valid   (m_tvalid),
        .pulse_out   (pulse_out),
        .delay_busy  (delay_busy)
    );

    assign m_tdata = {6'b0, delay_busy, pulse_out};

endmodule
